[rtl/desa_pkg.sv]
// shared types, codes, constants and the size-rounding function for the double-ended stack allocator
package desa_pkg;

	localparam int REGION_BYTES_DEF     = 16384;
	localparam int LOW_STACK_DEPTH_DEF  = 16;
	localparam int HIGH_STACK_DEPTH_DEF = 16;

	localparam int ADDR_W = 32;
	localparam int REQ_W  = 16;
	// rounded size can reach 65536
	localparam int SZ_W   = REQ_W + 1;
	// room for offset plus rounded size
	localparam int SUM_W  = SZ_W + 1;

	localparam logic [SZ_W-1:0]   GRAIN_MASK  = SZ_W'(16 - 1);
	localparam logic [ADDR_W-1:0] NIBBLE_MASK = 32'hf000_0000;
	localparam logic [ADDR_W-1:0] BASE_RESET  = 32'h7000_0000;

	typedef enum logic [1:0] {
		OP_ALLOC_LO = 2'd0,
		OP_FREE_LO  = 2'd1,
		OP_ALLOC_HI = 2'd2,
		OP_FREE_HI  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_HEAP_FALLBACK = 3'd1,
		ST_FAILED        = 3'd2,
		ST_HEAP_FREE     = 3'd3,
		ST_OVERFREE      = 3'd4
	} status_t;

	typedef struct packed {
		logic push_lo;
		logic pop_lo;
		logic push_hi;
		logic pop_hi;
	} stack_ctl_t;

	function automatic logic [SZ_W-1:0] round_size(input logic [REQ_W-1:0] req);
		round_size = ({1'b0, req} + GRAIN_MASK) & ~GRAIN_MASK;
	endfunction

endpackage

[rtl/double_ended_stack_allocator.sv]
// top level: input register, decision logic, both stacks and result register
// One request is taken per clock cycle when the result side keeps up. A request is
// registered at acceptance, resolved as it leaves the input register by the fit checks and
// at most one push or pop on the end's stack, and its result is registered and shown on
// out_valid; that input-register to result-register pass sets the rate of one
// request per cycle. Each stack keeps its newest entry in a register, so a free restores
// the offset at once while the entry beneath is read from the stack memory for the next
// free. The result register holds while out_stall is high and in_stall rises only when
// a request waits behind a stalled result. The region base may be written whenever
// cfg_valid is high and takes effect for requests resolved after the write.
module double_ended_stack_allocator #(
	parameter int REGION_BYTES     = desa_pkg::REGION_BYTES_DEF,
	parameter int LOW_STACK_DEPTH  = desa_pkg::LOW_STACK_DEPTH_DEF,
	parameter int HIGH_STACK_DEPTH = desa_pkg::HIGH_STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [desa_pkg::ADDR_W-1:0] scratchpad_base,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [desa_pkg::REQ_W-1:0]  request_size,
	input  logic [desa_pkg::ADDR_W-1:0] free_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [desa_pkg::ADDR_W-1:0] result_address,
	output logic [2:0]                  status
);

	localparam int OFS_W  = $clog2(REGION_BYTES + 1);
	localparam int LCNT_W = $clog2(LOW_STACK_DEPTH + 1);
	localparam int HCNT_W = $clog2(HIGH_STACK_DEPTH + 1);

	logic [desa_pkg::ADDR_W-1:0] base_q;

	logic                        valid_s1;
	desa_pkg::op_t               op_s1;
	logic [desa_pkg::REQ_W-1:0]  req_s1;
	logic [desa_pkg::ADDR_W-1:0] faddr_s1;

	logic                        valid_s2;
	logic [desa_pkg::ADDR_W-1:0] addr_s2;
	desa_pkg::status_t           status_s2;

	logic [OFS_W-1:0]  low_offset_q;
	logic [OFS_W-1:0]  high_offset_q;
	logic [OFS_W-1:0]  low_offset_nxt;
	logic [OFS_W-1:0]  high_offset_nxt;
	logic [LCNT_W-1:0] low_count;
	logic [HCNT_W-1:0] high_count;
	logic [OFS_W-1:0]  low_top;
	logic [OFS_W-1:0]  high_top;

	desa_pkg::stack_ctl_t        ctl;
	desa_pkg::stack_ctl_t        ctl_fire;
	logic [desa_pkg::ADDR_W-1:0] addr_c;
	desa_pkg::status_t           status_c;
	logic                        advance;
	logic                        in_fire;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= desa_pkg::BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= scratchpad_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= desa_pkg::op_t'(operation);
			req_s1   <= request_size;
			faddr_s1 <= free_address;
		end
	end

	desa_decide #(
		.REGION_BYTES     (REGION_BYTES),
		.LOW_STACK_DEPTH  (LOW_STACK_DEPTH),
		.HIGH_STACK_DEPTH (HIGH_STACK_DEPTH)
	) u_decide (
		.op              (op_s1),
		.req             (req_s1),
		.faddr           (faddr_s1),
		.base            (base_q),
		.low_offset      (low_offset_q),
		.high_offset     (high_offset_q),
		.low_count       (low_count),
		.high_count      (high_count),
		.low_top         (low_top),
		.high_top        (high_top),
		.ctl             (ctl),
		.low_offset_nxt  (low_offset_nxt),
		.high_offset_nxt (high_offset_nxt),
		.addr            (addr_c),
		.status          (status_c)
	);

	// stack and offset updates happen only on the cycle the request moves out
	assign ctl_fire = advance ? ctl : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_offset_q  <= '0;
			high_offset_q <= OFS_W'(REGION_BYTES);
		end else if (advance) begin
			low_offset_q  <= low_offset_nxt;
			high_offset_q <= high_offset_nxt;
		end
	end

	desa_stack #(
		.DEPTH (LOW_STACK_DEPTH),
		.W     (OFS_W)
	) u_low_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl_fire.push_lo),
		.pop       (ctl_fire.pop_lo),
		.push_data (low_offset_q),
		.count     (low_count),
		.top       (low_top)
	);

	desa_stack #(
		.DEPTH (HIGH_STACK_DEPTH),
		.W     (OFS_W)
	) u_high_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl_fire.push_hi),
		.pop       (ctl_fire.pop_hi),
		.push_data (high_offset_q),
		.count     (high_count),
		.top       (high_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2   <= addr_c;
			status_s2 <= status_c;
		end
	end

	assign out_valid      = valid_s2;
	assign result_address = addr_s2;
	assign status         = status_s2;

endmodule

[rtl/desa_stack.sv]
// lifo of saved offsets with the top entry cached in a register
module desa_stack #(
	parameter int DEPTH = desa_pkg::LOW_STACK_DEPTH_DEF,
	parameter int W     = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       pop,
	input  logic [W-1:0]               push_data,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic [W-1:0]               top
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]     mem [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [W-1:0]     top_q;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [CNT_W-1:0] below;

	assign below   = count_q - CNT_W'(2);
	assign wr_addr = AW'(count_q);
	// entry under the current top, becomes the top after a pop
	assign rd_addr = AW'(below);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_addr] <= push_data;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			top_q <= push_data;
		end else if (pop) begin
			top_q <= mem[rd_addr];
		end
	end

	assign count = count_q;
	assign top   = top_q;

endmodule

[rtl/desa_decide.sv]
// per-request decision: fit checks, new offsets, address and status
module desa_decide #(
	parameter int REGION_BYTES     = desa_pkg::REGION_BYTES_DEF,
	parameter int LOW_STACK_DEPTH  = desa_pkg::LOW_STACK_DEPTH_DEF,
	parameter int HIGH_STACK_DEPTH = desa_pkg::HIGH_STACK_DEPTH_DEF
) (
	input  desa_pkg::op_t                           op,
	input  logic [desa_pkg::REQ_W-1:0]              req,
	input  logic [desa_pkg::ADDR_W-1:0]             faddr,
	input  logic [desa_pkg::ADDR_W-1:0]             base,
	input  logic [$clog2(REGION_BYTES+1)-1:0]       low_offset,
	input  logic [$clog2(REGION_BYTES+1)-1:0]       high_offset,
	input  logic [$clog2(LOW_STACK_DEPTH+1)-1:0]    low_count,
	input  logic [$clog2(HIGH_STACK_DEPTH+1)-1:0]   high_count,
	input  logic [$clog2(REGION_BYTES+1)-1:0]       low_top,
	input  logic [$clog2(REGION_BYTES+1)-1:0]       high_top,
	output desa_pkg::stack_ctl_t                    ctl,
	output logic [$clog2(REGION_BYTES+1)-1:0]       low_offset_nxt,
	output logic [$clog2(REGION_BYTES+1)-1:0]       high_offset_nxt,
	output logic [desa_pkg::ADDR_W-1:0]             addr,
	output desa_pkg::status_t                       status
);

	localparam int OFS_W  = $clog2(REGION_BYTES + 1);
	localparam int LCNT_W = $clog2(LOW_STACK_DEPTH + 1);
	localparam int HCNT_W = $clog2(HIGH_STACK_DEPTH + 1);

	logic [desa_pkg::SZ_W-1:0]  sz;
	logic [desa_pkg::SUM_W-1:0] lo_ext;
	logic [desa_pkg::SUM_W-1:0] hi_ext;
	logic [desa_pkg::SUM_W-1:0] sz_ext;
	logic [desa_pkg::SUM_W-1:0] lo_end;
	logic [desa_pkg::SUM_W-1:0] hi_room;
	logic [desa_pkg::SUM_W-1:0] hi_new;
	logic                       low_full;
	logic                       high_full;
	logic                       foreign;

	assign sz      = desa_pkg::round_size(req);
	assign lo_ext  = desa_pkg::SUM_W'(low_offset);
	assign hi_ext  = desa_pkg::SUM_W'(high_offset);
	assign sz_ext  = desa_pkg::SUM_W'(sz);
	assign lo_end  = lo_ext + sz_ext;
	// never negative, low offset stays at or below high offset
	assign hi_room = hi_ext - lo_ext;
	assign hi_new  = hi_ext - sz_ext;

	assign low_full  = low_count >= LCNT_W'(LOW_STACK_DEPTH);
	assign high_full = high_count >= HCNT_W'(HIGH_STACK_DEPTH);
	assign foreign   = (faddr & desa_pkg::NIBBLE_MASK) != (base & desa_pkg::NIBBLE_MASK);

	always_comb begin
		ctl             = '0;
		low_offset_nxt  = low_offset;
		high_offset_nxt = high_offset;
		addr            = '0;
		status          = desa_pkg::ST_OK;
		unique case (op)
			desa_pkg::OP_ALLOC_LO: begin
				if (lo_end > hi_ext || low_full) begin
					status = desa_pkg::ST_HEAP_FALLBACK;
				end else begin
					ctl.push_lo    = 1'b1;
					addr           = base + desa_pkg::ADDR_W'(low_offset);
					low_offset_nxt = OFS_W'(lo_end);
				end
			end
			desa_pkg::OP_FREE_LO: begin
				priority if (foreign) begin
					status = desa_pkg::ST_HEAP_FREE;
				end else if (low_count == '0) begin
					status = desa_pkg::ST_OVERFREE;
				end else begin
					ctl.pop_lo     = 1'b1;
					low_offset_nxt = low_top;
				end
			end
			desa_pkg::OP_ALLOC_HI: begin
				if (sz_ext > hi_room || high_full) begin
					status = desa_pkg::ST_FAILED;
				end else begin
					ctl.push_hi     = 1'b1;
					high_offset_nxt = OFS_W'(hi_new);
					addr            = base + desa_pkg::ADDR_W'(hi_new);
				end
			end
			desa_pkg::OP_FREE_HI: begin
				if (high_count == '0) begin
					status = desa_pkg::ST_OVERFREE;
				end else begin
					ctl.pop_hi      = 1'b1;
					high_offset_nxt = high_top;
				end
			end
			default: begin
				status = desa_pkg::ST_OK;
			end
		endcase
	end

endmodule

[rtl/desa_checker.sv]
// port-level assertions for the allocator, bound to the top level
module desa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [desa_pkg::ADDR_W-1:0] scratchpad_base,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [1:0]                  operation,
	input logic [desa_pkg::REQ_W-1:0]  request_size,
	input logic [desa_pkg::ADDR_W-1:0] free_address,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [desa_pkg::ADDR_W-1:0] result_address,
	input logic [2:0]                  status
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_address) && $stable(status))
		else $error("result beat changed while stalled");

	// the input side only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no result waiting");

	// an accepted beat passes through the input register, then a result is shown
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted beat gave no result");

	// failed allocs and frees return no address
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(desa_pkg::ST_OK) |-> result_address == '0)
		else $error("nonzero address with non-ok status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(desa_pkg::ST_OVERFREE))
		else $error("status code out of range");

endmodule

bind double_ended_stack_allocator desa_checker u_desa_checker (.*);

[verif/double_ended_stack_allocator_tb.sv]
// testbench for the double-ended stack allocator: random and directed requests against a predictor
module double_ended_stack_allocator_tb;
	import desa_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_ITEMS = 285;

	typedef enum int {
		MIX_NONE,
		MIX_SENDER,
		MIX_RECEIVER,
		MIX_BOTH
	} idle_mix_t;

	class alloc_scoreboard;
		logic [ADDR_W-1:0] base;
		logic [14:0] lo_off;
		logic [14:0] hi_off;
		logic [4:0] lo_cnt;
		logic [4:0] hi_cnt;
		logic [14:0] lo_saved [LOW_STACK_DEPTH_DEF];
		logic [14:0] hi_saved [HIGH_STACK_DEPTH_DEF];
		logic [ADDR_W-1:0] addr_q [$];
		status_t status_q [$];
		int errors;
		int accepted;
		int base_writes;
		int seen [5];

		function new();
			base = BASE_RESET;
			lo_off = '0;
			hi_off = 15'(REGION_BYTES_DEF);
			lo_cnt = '0;
			hi_cnt = '0;
			errors = 0;
			accepted = 0;
			base_writes = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void set_base(logic [ADDR_W-1:0] value);
			base = value;
			base_writes++;
		endfunction

		function int pending();
			return addr_q.size();
		endfunction

		// work out the outcome of one accepted request and queue it
		function void note_request(op_t op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] faddr);
			logic [31:0] sz;
			logic [ADDR_W-1:0] addr;
			status_t st;
			sz = ({16'b0, req} + 32'd15) & ~32'd15;
			addr = '0;
			st = ST_OK;
			accepted++;
			case (op)
			OP_ALLOC_LO: begin
				if (32'(lo_off) + sz > 32'(hi_off) || lo_cnt >= LOW_STACK_DEPTH_DEF) begin
					st = ST_HEAP_FALLBACK;
				end else begin
					lo_saved[lo_cnt] = lo_off;
					addr = base + 32'(lo_off);
					lo_off = 15'(32'(lo_off) + sz);
					lo_cnt++;
				end
			end
			OP_FREE_LO: begin
				if ((faddr & NIBBLE_MASK) != (base & NIBBLE_MASK)) begin
					st = ST_HEAP_FREE;
				end else if (lo_cnt == 0) begin
					st = ST_OVERFREE;
				end else begin
					lo_cnt--;
					lo_off = lo_saved[lo_cnt];
				end
			end
			OP_ALLOC_HI: begin
				// the gap is never negative, so no wrap in this compare
				if (sz > 32'(hi_off) - 32'(lo_off) || hi_cnt >= HIGH_STACK_DEPTH_DEF) begin
					st = ST_FAILED;
				end else begin
					hi_saved[hi_cnt] = hi_off;
					hi_off = 15'(32'(hi_off) - sz);
					hi_cnt++;
					addr = base + 32'(hi_off);
				end
			end
			default: begin
				if (hi_cnt == 0) begin
					st = ST_OVERFREE;
				end else begin
					hi_cnt--;
					hi_off = hi_saved[hi_cnt];
				end
			end
			endcase
			addr_q.push_back(addr);
			status_q.push_back(st);
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_result(logic [ADDR_W-1:0] addr, logic [2:0] st);
			logic [ADDR_W-1:0] want_addr;
			status_t want_st;
			if (st <= 3'(ST_OVERFREE))
				seen[st]++;
			if (addr_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: address %h status %0d",
					$time, addr, st);
				return;
			end
			want_addr = addr_q.pop_front();
			want_st = status_q.pop_front();
			if (addr !== want_addr)
				report("result_address", want_addr, addr);
			if (st !== 3'(want_st))
				report("status", 32'(want_st), 32'(st));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ADDR_W-1:0] scratchpad_base = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [REQ_W-1:0] request_size = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ADDR_W-1:0] result_address;
	logic [2:0] status;

	alloc_scoreboard sb;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	double_ended_stack_allocator uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.scratchpad_base(scratchpad_base),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.request_size   (request_size),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_address (result_address),
		.status         (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stall, or a long hold when one is asked for
	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(result_address, status);
			if (in_valid && !in_stall)
				sb.note_request(op_t'(operation), request_size, free_address);
			if (cfg_valid && cfg_ready)
				sb.set_base(scratchpad_base);
		end
	end

	task automatic send_request(op_t op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] faddr);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_size <= req;
		free_address <= faddr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sender pause until every queued result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_base(logic [ADDR_W-1:0] value);
		cfg_valid <= 1'b1;
		scratchpad_base <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// grow bursts push both stacks toward full, shrink bursts pop them back
	task automatic send_random(bit grow);
		op_t op;
		logic [REQ_W-1:0] req;
		logic [ADDR_W-1:0] faddr;
		int pick;
		pick = $urandom_range(99);
		if (pick < (grow ? 70 : 30))
			op = $urandom_range(1) ? OP_ALLOC_LO : OP_ALLOC_HI;
		else
			op = $urandom_range(1) ? OP_FREE_LO : OP_FREE_HI;
		pick = $urandom_range(99);
		if (pick < 55)
			req = 16'($urandom_range(64));
		else if (pick < 85)
			req = 16'($urandom_range(2048));
		else
			req = 16'($urandom);
		faddr = $urandom;
		if ($urandom_range(99) < 85)
			faddr = (sb.base & NIBBLE_MASK) | (faddr & ~NIBBLE_MASK);
		send_request(op, req, faddr);
	endtask

	task automatic run_phase(int n, idle_mix_t mix);
		bit grow;
		grow = 1'b1;
		case (mix)
		MIX_NONE: begin
			send_idle = 0;
			recv_stall = 0;
			// long output hold while requests keep coming
			hold_ask++;
		end
		MIX_SENDER: begin
			send_idle = 45;
			recv_stall = 0;
		end
		MIX_RECEIVER: begin
			send_idle = 0;
			recv_stall = 45;
		end
		default: begin
			send_idle = 17;
			recv_stall = 17;
		end
		endcase
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				grow = 1'($urandom_range(1));
			if (i == n / 2)
				wait_drained();
			send_random(grow);
		end
		wait_drained();
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [ADDR_W-1:0] bases [6];
		sb = new();
		bases[0] = 32'h0000_0000;
		bases[1] = 32'hffff_fff0;
		bases[2] = 32'hffff_ffff;
		bases[3] = {28'($urandom_range(32'h0fff_ffff, 0)), 4'h0};
		bases[4] = $urandom;
		bases[5] = BASE_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under the reset base
		send_request(OP_FREE_LO, 16'h0000, BASE_RESET | 32'h0123_4567);
		send_request(OP_FREE_HI, 16'hffff, 32'hffff_ffff);
		send_request(OP_FREE_LO, 16'h0000, 32'hffff_ffff);
		send_request(OP_FREE_LO, 16'h0000, 32'h0000_0000);
		send_request(OP_ALLOC_LO, 16'hffff, 32'h0);
		send_request(OP_ALLOC_HI, 16'hffff, 32'h0);
		send_request(OP_ALLOC_HI, 16'h4001, 32'h0);
		send_request(OP_ALLOC_LO, 16'h0000, 32'h0);
		send_request(OP_ALLOC_LO, 16'h0001, 32'h0);
		send_request(OP_ALLOC_LO, 16'h0011, 32'h0);
		send_request(OP_ALLOC_HI, 16'h0000, 32'h0);
		send_request(OP_ALLOC_HI, 16'h0010, 32'h0);
		// takes exactly the gap that is left
		send_request(OP_ALLOC_HI, 16'd16320, 32'h0);
		send_request(OP_ALLOC_LO, 16'h0001, 32'h0);
		send_request(OP_ALLOC_HI, 16'h0001, 32'h0);
		send_request(OP_ALLOC_LO, 16'h0000, 32'h0);
		send_request(OP_FREE_HI, 16'h0000, 32'h0);
		repeat (5) send_request(OP_FREE_LO, 16'h0000, BASE_RESET | 32'h0fff_ffff);
		repeat (3) send_request(OP_FREE_HI, 16'h0000, 32'h0);
		wait_drained();

		run_phase(PHASE_ITEMS, MIX_NONE);
		for (int p = 0; p < 6; p++) begin
			write_base(bases[p]);
			run_phase(PHASE_ITEMS, idle_mix_t'((p + 1) % 4));
		end

		wait_drained();
		repeat (8) @(negedge clk);
		$display("run covered %0d requests over %0d base writes, with idle gaps, stalls and hold-offs",
			sb.accepted, sb.base_writes);
		$display("results: ok %0d, heap fallback %0d, failed %0d, heap free %0d, overfree %0d",
			sb.seen[ST_OK], sb.seen[ST_HEAP_FALLBACK], sb.seen[ST_FAILED],
			sb.seen[ST_HEAP_FREE], sb.seen[ST_OVERFREE]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
